// File: rtl/core/imadec_pkg.sv
`timescale 1ns / 1ps

package imadec_pkg;

    localparam logic signed [17:0] PRED_MAX = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN = -18'sd32768;
    localparam logic [6:0]         POS_MAX  = 7'd88;
    localparam int                 STEP_COUNT = 89;

    localparam logic [14:0] STEP_SIZES [STEP_COUNT] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] INDEX_MOVES [16] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    typedef struct packed {
        logic decode;
        logic restart;
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [7:0] first;
        logic signed [7:0] second;
    } lane_samples_t;

    typedef struct packed {
        logic signed [15:0] pred;
        logic [6:0]         pos;
        logic signed [7:0]  sample;
    } nibble_result_t;

    function automatic nibble_result_t decode_nibble(
        input logic [3:0]         code,
        input logic signed [15:0] pred,
        input logic [6:0]         pos
    );
        logic [6:0]         p;
        logic [14:0]        step;
        logic [18:0]        prod;
        logic [15:0]        diff;
        logic [17:0]        ext_pred;
        logic [17:0]        ext_diff;
        logic signed [17:0] v;
        logic signed [4:0]  move;
        logic signed [7:0]  np;
        nibble_result_t     r;
        p        = (pos > POS_MAX) ? POS_MAX : pos;
        step     = STEP_SIZES[p];
        prod     = {15'd0, code[2:0], 1'b1} * {4'd0, step};
        diff     = prod[18:3];
        ext_pred = {pred[15], pred[15], pred};
        ext_diff = {2'b00, diff};
        if (code[3]) begin
            v = $signed(ext_pred - ext_diff);
        end else begin
            v = $signed(ext_pred + ext_diff);
        end
        if (v > PRED_MAX) begin
            r.pred = 16'sh7fff;
        end else if (v < PRED_MIN) begin
            r.pred = 16'sh8000;
        end else begin
            r.pred = v[15:0];
        end
        move = INDEX_MOVES[code];
        np   = $signed({1'b0, p}) + $signed({{3{move[4]}}, move});
        if (np[7]) begin
            r.pos = 7'd0;
        end else if (np[6:0] > POS_MAX) begin
            r.pos = POS_MAX;
        end else begin
            r.pos = np[6:0];
        end
        r.sample = r.pred[15:8];
        return r;
    endfunction

endpackage

// File: rtl/core/ima_adpcm_nibble_decoder_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// s_        in         s_tvalid / s_tready        s_tdata 16 bits, s_tuser 1 bit
// m_        out        m_tvalid / m_tready        m_tdata 16 bits
// cfg_      in         cfg_valid / cfg_ready      cfg_data 1 bit (stereo_mode)
//
// one transaction in each cycle while s_tready is high; result registered in the cycle after acceptance
// the left lane, and in stereo mode the right lane, run two chained nibble updates in the accepting cycle
// the output register frees s_tready whenever m_tready takes the pending result
// aresetn clears predictors, step positions, stereo_mode and the output valid
// cfg_ready is always high

module ima_adpcm_nibble_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // left_code_byte, right_code_byte
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // first_sample, second_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import imadec_pkg::*;

    logic          stereo_mode_reg;
    logic          stereo_mode_next;
    logic          accept;
    lane_ctrl_t    left_ctrl;
    lane_ctrl_t    right_ctrl;
    lane_samples_t left_samples;
    lane_samples_t right_samples;
    lane_samples_t out_samples;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign stereo_mode_next = (cfg_valid && cfg_ready) ? cfg_data : stereo_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stereo_mode_reg <= 1'b0;
        end else begin
            stereo_mode_reg <= stereo_mode_next;
        end
    end

    // right lane still clears on restart in mono
    assign left_ctrl.decode   = accept;
    assign left_ctrl.restart  = accept && s_tuser;
    assign right_ctrl.decode  = accept && stereo_mode_reg;
    assign right_ctrl.restart = accept && s_tuser;

    imadec_lane u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (left_ctrl),
        .code_byte (s_tdata[7:0]),
        .samples   (left_samples)
    );

    imadec_lane u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (right_ctrl),
        .code_byte (s_tdata[15:8]),
        .samples   (right_samples)
    );

    imadec_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .take          (m_tready),
        .stereo        (stereo_mode_reg),
        .left_samples  (left_samples),
        .right_samples (right_samples),
        .out_valid     (m_tvalid),
        .out_samples   (out_samples)
    );

    assign m_tdata = {out_samples.second, out_samples.first};

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted transaction gave no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser && (s_tdata[7:0] == 8'd0)
            && (!stereo_mode_reg || (s_tdata[15:8] == 8'd0)))
        |=> (m_tdata == 16'd0))
        else $error("restart with zero codes gave nonzero samples");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !accept) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result lost while stalled");

endmodule

// File: rtl/core/imadec_lane.sv
`timescale 1ns / 1ps

module imadec_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  imadec_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]             code_byte,
    output imadec_pkg::lane_samples_t samples
);
    import imadec_pkg::*;

    logic signed [15:0] pred_reg;
    logic signed [15:0] pred_next;
    logic [6:0]         pos_reg;
    logic [6:0]         pos_next;
    logic signed [15:0] pred_start;
    logic [6:0]         pos_start;
    nibble_result_t     low_res;
    nibble_result_t     high_res;

    // restart zeroes the state ahead of the first nibble
    assign pred_start = ctrl.restart ? 16'sd0 : pred_reg;
    assign pos_start  = ctrl.restart ? 7'd0 : pos_reg;

    // two chained nibble updates, low nibble first
    assign low_res  = decode_nibble(code_byte[3:0], pred_start, pos_start);
    assign high_res = decode_nibble(code_byte[7:4], low_res.pred, low_res.pos);

    assign samples.first  = low_res.sample;
    assign samples.second = high_res.sample;

    always_comb begin
        pred_next = pred_reg;
        pos_next  = pos_reg;
        if (ctrl.decode) begin
            pred_next = high_res.pred;
            pos_next  = high_res.pos;
        end else if (ctrl.restart) begin
            pred_next = 16'sd0;
            pos_next  = 7'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pred_reg <= 16'sd0;
            pos_reg  <= 7'd0;
        end else begin
            pred_reg <= pred_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// File: rtl/core/imadec_merge.sv
`timescale 1ns / 1ps

module imadec_merge (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic                      take,
    input  logic                      stereo,
    input  imadec_pkg::lane_samples_t left_samples,
    input  imadec_pkg::lane_samples_t right_samples,
    output logic                      out_valid,
    output imadec_pkg::lane_samples_t out_samples
);
    import imadec_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    lane_samples_t samples_reg;
    lane_samples_t merged;

    // average truncated toward zero
    function automatic logic signed [7:0] lane_average(
        input logic signed [7:0] a,
        input logic signed [7:0] b
    );
        logic [8:0] sum;
        logic [8:0] adj;
        sum = {a[7], a} + {b[7], b};
        adj = sum + {8'd0, sum[8]};
        return adj[8:1];
    endfunction

    always_comb begin
        if (stereo) begin
            merged.first  = lane_average(left_samples.first, right_samples.first);
            merged.second = lane_average(left_samples.second, right_samples.second);
        end else begin
            merged = left_samples;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            samples_reg <= merged;
        end
    end

    assign out_valid   = valid_reg;
    assign out_samples = samples_reg;

endmodule
